// ===== rtl/core/per_key_counter_rate_macros.svh =====
// ----------------------------------------------------------------------------
// per_key_counter_rate_macros
// Assertion helpers for the per-key counter rate block; each expects
// clk and rst_n in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PER_KEY_COUNTER_RATE_MACROS_SVH
`define PER_KEY_COUNTER_RATE_MACROS_SVH

// same-cycle implication
`define PKR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pkr_pkg.sv =====
// ----------------------------------------------------------------------------
// pkr_pkg
// Shared widths, constants, queue job type and state encodings of the
// per-key counter rate block.
// ----------------------------------------------------------------------------
package pkr_pkg;

  // table depth default
  localparam int COMPONENTS_DEF = 4096;

  // item field widths
  localparam int COMP_W  = 12;
  localparam int SEC_W   = 32;
  localparam int US_W    = 20;
  localparam int CNT_W   = 64;
  localparam int RATE_W  = 64;
  localparam int DATA_W  = 128;

  // table entry {seconds, micros, count}
  localparam int ENTRY_W = SEC_W + US_W + CNT_W;

  // wide enough for any component limit
  localparam int IDX_W = 21;

  // arithmetic widths
  localparam int DS_W     = SEC_W + 1;
  localparam int DU_W     = US_W + 1;
  localparam int DT_W     = 54;
  localparam int DIV_W    = 53;
  localparam int HALF_W   = CNT_W / 2;
  localparam int PROD_W   = HALF_W + US_W;
  localparam int DVD_W    = CNT_W + US_W;
  localparam int DVD_HI_W = DVD_W - CNT_W;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;

  // one division job handed from front to back
  typedef struct packed {
    logic [COMP_W-1:0] comp;
    logic [SEC_W-1:0]  sec;
    logic [US_W-1:0]   us;
    logic [DVD_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } job_t;

  typedef enum logic [2:0] {
    F_CLR,
    F_IDLE,
    F_RD,
    F_MUL,
    F_DT,
    F_PLO,
    F_PHI,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHK,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/core/pkr_ram.sv =====
// ----------------------------------------------------------------------------
// pkr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pkr_front.sv =====
// ----------------------------------------------------------------------------
// pkr_front
// Accepts samples, clears and owns the history table, works out the time
// and counter deltas and queues a division job when a rate is due.
// ----------------------------------------------------------------------------
module pkr_front #(
  parameter int COMPONENTS = pkr_pkg::COMPONENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pkr_pkg::DATA_W-1:0]  in_tdata,
  output logic                        q_push,
  output pkr_pkg::job_t               q_job,
  input  logic                        q_ready,
  output logic                        clearing
);

  import pkr_pkg::*;

  localparam int AW = $clog2(COMPONENTS);
  localparam logic [AW-1:0]    LAST_IDX   = AW'(COMPONENTS - 1);
  localparam logic [IDX_W-1:0] COMP_LIMIT = IDX_W'(COMPONENTS);
  localparam logic signed [DU_W-1:0] US_S = {1'b0, US_PER_SEC};

  front_state_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r;

  // latched item
  logic [COMP_W-1:0] comp_r;
  logic [SEC_W-1:0]  sec_r;
  logic [US_W-1:0]   us_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              in_range_r;

  // delta pipeline
  logic signed [DS_W-1:0] ds_r;
  logic signed [DU_W-1:0] du_r;
  logic signed [DT_W-1:0] prod_r;
  logic signed [DT_W-1:0] dt_r;
  logic [CNT_W-1:0]       dv_r;
  logic                   empty_r;
  logic [PROD_W-1:0]      plo_r;
  logic [PROD_W-1:0]      phi_r;

  // input unpacking, component lowest
  logic [COMP_W-1:0] in_comp;
  logic [SEC_W-1:0]  in_sec;
  logic [US_W-1:0]   in_us;
  logic [CNT_W-1:0]  in_cnt;
  logic [IDX_W-1:0]  in_comp_ext;
  logic [IDX_W-1:0]  comp_ext;

  assign in_comp     = in_tdata[COMP_W-1:0];
  assign in_sec      = in_tdata[COMP_W+SEC_W-1:COMP_W];
  assign in_us       = in_tdata[COMP_W+SEC_W+US_W-1:COMP_W+SEC_W];
  assign in_cnt      = in_tdata[DATA_W-1:COMP_W+SEC_W+US_W];
  assign in_comp_ext = {{(IDX_W-COMP_W){1'b0}}, in_comp};
  assign comp_ext    = {{(IDX_W-COMP_W){1'b0}}, comp_r};

  // history table
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [SEC_W-1:0]   prev_sec;
  logic [US_W-1:0]    prev_us;
  logic [CNT_W-1:0]   prev_cnt;

  pkr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (COMPONENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_comp_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign prev_sec = ram_rdata[ENTRY_W-1:US_W+CNT_W];
  assign prev_us  = ram_rdata[US_W+CNT_W-1:CNT_W];
  assign prev_cnt = ram_rdata[CNT_W-1:0];

  // rate is due only after a real earlier sample and a positive gap
  logic emit;
  assign emit = !empty_r && !dt_r[DT_W-1] && (dt_r != '0);

  // state register and clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_CLR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_CLR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end
  end

  // next state, handshake and table write
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    q_push    = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = comp_ext[AW-1:0];
    ram_wdata = {sec_r, us_r, cnt_r};
    unique case (state_r)
      F_CLR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = F_RD;
        end
      end
      F_RD: begin
        ram_we    = in_range_r;
        state_nxt = in_range_r ? F_MUL : F_IDLE;
      end
      F_MUL: state_nxt = F_DT;
      F_DT:  state_nxt = F_PLO;
      F_PLO: state_nxt = emit ? F_PHI : F_IDLE;
      F_PHI: state_nxt = F_PUSH;
      F_PUSH: begin
        q_push = 1'b1;
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        comp_r     <= in_comp;
        sec_r      <= in_sec;
        us_r       <= in_us;
        cnt_r      <= in_cnt;
        in_range_r <= (in_comp_ext < COMP_LIMIT);
      end
      F_RD: begin
        ds_r    <= $signed({1'b0, sec_r}) - $signed({1'b0, prev_sec});
        du_r    <= $signed({1'b0, us_r}) - $signed({1'b0, prev_us});
        dv_r    <= cnt_r - prev_cnt;
        empty_r <= (prev_sec == '0);
      end
      F_MUL: prod_r <= DT_W'(ds_r) * DT_W'(US_S);
      F_DT:  dt_r   <= prod_r + DT_W'(du_r);
      F_PLO: plo_r  <= PROD_W'(dv_r[HALF_W-1:0]) * PROD_W'(US_PER_SEC);
      F_PHI: phi_r  <= PROD_W'(dv_r[CNT_W-1:HALF_W]) * PROD_W'(US_PER_SEC);
      default: ;
    endcase
  end

  // job for the divider: dividend = delta * 1e6
  always_comb begin
    q_job.comp     = comp_r;
    q_job.sec      = sec_r;
    q_job.us       = us_r;
    q_job.dividend = {phi_r, {HALF_W{1'b0}}} + DVD_W'(plo_r);
    q_job.divisor  = DIV_W'($unsigned(dt_r));
  end

endmodule

// ===== rtl/core/pkr_queue.sv =====
// ----------------------------------------------------------------------------
// pkr_queue
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module pkr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pkr_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output pkr_pkg::job_t pop_job,
  output logic          pop_valid
);

  import pkr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   FULL_CNT = (PW + 1)'(QUEUE_DEPTH);

  job_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      priority if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PW + 1)'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/pkr_back.sv =====
// ----------------------------------------------------------------------------
// pkr_back
// Radix-2 restoring divider for rate = delta * 1e6 / dt with saturation,
// followed by the result register.
// ----------------------------------------------------------------------------
module pkr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  pkr_pkg::job_t               q_job,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pkr_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tuser
);

  import pkr_pkg::*;

  localparam int ITER_W = $clog2(RATE_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(RATE_W - 1);

  back_state_t state_r, state_nxt;
  logic [ITER_W-1:0] iter_r;

  // divider working registers
  logic [DIV_W-1:0]    rem_r;
  logic [RATE_W-1:0]   quo_r;
  logic [DVD_HI_W-1:0] hi_r;
  logic [DIV_W-1:0]    d_r;
  logic                sat_r;

  // result metadata
  logic [COMP_W-1:0] comp_r;
  logic [SEC_W-1:0]  sec_r;
  logic [US_W-1:0]   us_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_user_r;
  logic              load_out;

  // one quotient bit per cycle
  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           ge;
  logic           too_big;

  assign shifted = {rem_r, quo_r[RATE_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = (shifted >= {1'b0, d_r});
  assign too_big = ({{(DIV_W-DVD_HI_W){1'b0}}, hi_r} >= d_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_nxt = B_CHK;
        end
      end
      B_CHK: state_nxt = too_big ? B_DONE : B_RUN;
      B_RUN: begin
        if (iter_r == '0) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        load_out = !out_valid_r || out_tready;
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      priority if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        comp_r <= q_job.comp;
        sec_r  <= q_job.sec;
        us_r   <= q_job.us;
        hi_r   <= q_job.dividend[DVD_W-1:CNT_W];
        quo_r  <= q_job.dividend[CNT_W-1:0];
        d_r    <= q_job.divisor;
      end
      B_CHK: begin
        sat_r  <= too_big;
        rem_r  <= DIV_W'(hi_r);
        iter_r <= ITER_LAST;
        if (too_big) begin
          quo_r <= '1;
        end
      end
      B_RUN: begin
        rem_r  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_r  <= {quo_r[RATE_W-2:0], ge};
        iter_r <= iter_r - ITER_W'(1);
      end
      default: ;
    endcase
  end

  // result register: component, seconds, micros, rate from the lowest bit
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {quo_r, us_r, sec_r, comp_r};
      out_user_r <= sat_r;
    end
  end

endmodule

// ===== rtl/core/per_key_counter_rate.sv =====
// ----------------------------------------------------------------------------
// per_key_counter_rate
// Per-component counter rate: keeps the last sample of each component and
// emits counts per second between consecutive samples, saturated at 64 bits.
//
//   channel  dir  tdata (lsb first)                       tuser
//   in_      in   component 12, seconds 32, micros 20,    -
//                 count 64
//   out_     out  out_component 12, out_seconds 32,       clipped
//                 out_micros 20, rate 64
//
// A sample passes the front states read (table read and write), multiply,
// delta and low product, or only read when its component is out of range;
// one that yields a rate adds high product and push, and the back runs the
// one-bit-per-cycle 64-step divider, skipped when the rate saturates,
// before it takes the next job. After reset the table is cleared one entry
// a cycle, with in_tready low. A stalled output holds its result while the
// divider starts the next queued job; a full queue stalls the front.
// ----------------------------------------------------------------------------
module per_key_counter_rate #(
  parameter int COMPONENTS = pkr_pkg::COMPONENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // component, seconds, micros, count
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pkr_pkg::DATA_W-1:0] in_tdata,
  // out_component, out_seconds, out_micros, rate
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pkr_pkg::DATA_W-1:0] out_tdata,
  // clipped
  output logic                       out_tuser
);

  import pkr_pkg::*;

  `include "per_key_counter_rate_macros.svh"

  job_t front_job;
  job_t back_job;
  logic q_push;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  logic clearing;

  // classify and update history
  pkr_front #(
    .COMPONENTS (COMPONENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_job     (front_job),
    .q_ready   (q_ready),
    .clearing  (clearing)
  );

  // decoupling queue
  pkr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (front_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_job    (back_job),
    .pop_valid  (q_valid)
  );

  // divide and deliver
  pkr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_job      (back_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // checks
  `PKR_ASSERT_IMP(a_no_accept_in_clear, clearing, !in_tready, "item taken during table clear")
  `PKR_ASSERT_IMP(a_no_result_in_clear, clearing, !out_tvalid, "result during table clear")
  `PKR_ASSERT_NXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "front took two items")
  `PKR_ASSERT_IMP(a_clip_is_max, out_tvalid && out_tuser, out_tdata[127:64] == '1, "clip not max")

endmodule
